>>> rtl/core/srp_pkg.sv
// types and constants shared by the sensor record parser
`default_nettype none
package srp_pkg;

   localparam int POS_W = 8;
   localparam int ACC_W = 17;
   localparam int FIELD_W = 4;

   localparam logic [7:0] ASCII_NUL  = 8'd0;
   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_NINE = 8'd57;

   localparam int YEAR_DIGITS  = 4;
   localparam int TIME_DIGITS  = 2;
   localparam int VALUE_DIGITS = 5;

   localparam logic [FIELD_W-1:0] FLD_CLIENT  = 4'd0;
   localparam logic [FIELD_W-1:0] FLD_CONTROL = 4'd1;
   localparam logic [FIELD_W-1:0] FLD_YEAR    = 4'd2;
   localparam logic [FIELD_W-1:0] FLD_MONTH   = 4'd3;
   localparam logic [FIELD_W-1:0] FLD_DAY     = 4'd4;
   localparam logic [FIELD_W-1:0] FLD_HOUR    = 4'd5;
   localparam logic [FIELD_W-1:0] FLD_MINUTE  = 4'd6;
   localparam logic [FIELD_W-1:0] FLD_SECOND  = 4'd7;
   localparam logic [FIELD_W-1:0] FLD_HUB     = 4'd8;
   localparam logic [FIELD_W-1:0] FLD_ID      = 4'd9;
   localparam logic [FIELD_W-1:0] FLD_TYPE    = 4'd10;

   typedef struct packed {
      logic [FIELD_W-1:0] field_id;
      logic [7:0]         text_byte;
      logic               text_valid;
      logic [ACC_W-1:0]   number;
      logic               number_valid;
      logic               bad_digit;
      logic               record_last;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/sensor_record_parser.sv
// sensor record parser: byte stream in, one tagged field item out per byte
//
// req channel: one record byte per item in req_tdata. rsp channel: one item per
// accepted byte, giving the field it belongs to, the byte itself for text
// fields and, on the last byte of a numeric field, its decoded decimal value.
// the final byte of a record carries rsp_tlast.
// rsp_tvalid rises in the cycle after acceptance; one byte per cycle is
// sustained while rsp_tready stays high, set by the single output register
// and the multiply-by-ten accumulate with the position compare in front of it.
// a new byte is taken whenever the output register is empty or being read in
// the same cycle, so a stalled receiver holds the result and, one item later,
// the sender.
// reset (synchronous, active high) returns to the start of a record with a
// cleared accumulator and an empty output register.
// the record length follows from the text field length parameters.
`default_nettype none
module sensor_record_parser
   import srp_pkg::*;
#(
   parameter int CLIENT_LEN      = 8,
   parameter int CONTROL_LEN     = 8,
   parameter int HUB_NAME_LEN    = 8,
   parameter int SENSOR_ID_LEN   = 8,
   parameter int SENSOR_TYPE_LEN = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // byte_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // text_byte, number, zero pad
   output logic [7:0]       rsp_tuser,   // field_id, text_valid, number_valid, bad_digit, pad
   output logic             rsp_tlast    // record_last
);

   localparam int END_CLIENT  = CLIENT_LEN;
   localparam int END_CONTROL = END_CLIENT + CONTROL_LEN;
   localparam int END_YEAR    = END_CONTROL + YEAR_DIGITS;
   localparam int END_MONTH   = END_YEAR + TIME_DIGITS;
   localparam int END_DAY     = END_MONTH + TIME_DIGITS;
   localparam int END_HOUR    = END_DAY + TIME_DIGITS;
   localparam int END_MINUTE  = END_HOUR + TIME_DIGITS;
   localparam int END_SECOND  = END_MINUTE + TIME_DIGITS;
   localparam int END_HUB     = END_SECOND + HUB_NAME_LEN;
   localparam int END_ID      = END_HUB + SENSOR_ID_LEN;
   localparam int END_TYPE    = END_ID + SENSOR_TYPE_LEN;
   localparam int RECORD_LEN  = END_TYPE + VALUE_DIGITS;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_LEN - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             stop_ff, stop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [FIELD_W-1:0] seg_id;
   logic               seg_numeric;
   logic [POS_W-1:0]   seg_last_pos;
   logic               seg_last;
   logic               is_digit;
   logic [7:0]         digit_diff;
   logic [ACC_W-1:0]   acc_x10;
   logic [ACC_W-1:0]   acc_step;
   logic               accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (pos_ff < POS_W'(END_CLIENT)) begin
         seg_id = FLD_CLIENT;  seg_numeric = 1'b0; seg_last_pos = POS_W'(END_CLIENT - 1);
      end else if (pos_ff < POS_W'(END_CONTROL)) begin
         seg_id = FLD_CONTROL; seg_numeric = 1'b0; seg_last_pos = POS_W'(END_CONTROL - 1);
      end else if (pos_ff < POS_W'(END_YEAR)) begin
         seg_id = FLD_YEAR;    seg_numeric = 1'b1; seg_last_pos = POS_W'(END_YEAR - 1);
      end else if (pos_ff < POS_W'(END_MONTH)) begin
         seg_id = FLD_MONTH;   seg_numeric = 1'b1; seg_last_pos = POS_W'(END_MONTH - 1);
      end else if (pos_ff < POS_W'(END_DAY)) begin
         seg_id = FLD_DAY;     seg_numeric = 1'b1; seg_last_pos = POS_W'(END_DAY - 1);
      end else if (pos_ff < POS_W'(END_HOUR)) begin
         seg_id = FLD_HOUR;    seg_numeric = 1'b1; seg_last_pos = POS_W'(END_HOUR - 1);
      end else if (pos_ff < POS_W'(END_MINUTE)) begin
         seg_id = FLD_MINUTE;  seg_numeric = 1'b1; seg_last_pos = POS_W'(END_MINUTE - 1);
      end else if (pos_ff < POS_W'(END_SECOND)) begin
         seg_id = FLD_SECOND;  seg_numeric = 1'b1; seg_last_pos = POS_W'(END_SECOND - 1);
      end else if (pos_ff < POS_W'(END_HUB)) begin
         seg_id = FLD_HUB;     seg_numeric = 1'b0; seg_last_pos = POS_W'(END_HUB - 1);
      end else if (pos_ff < POS_W'(END_ID)) begin
         seg_id = FLD_ID;      seg_numeric = 1'b0; seg_last_pos = POS_W'(END_ID - 1);
      end else if (pos_ff < POS_W'(END_TYPE)) begin
         seg_id = FLD_TYPE;    seg_numeric = 1'b0; seg_last_pos = POS_W'(END_TYPE - 1);
      end else begin
         // sensor value shares the type id
         seg_id = FLD_TYPE;    seg_numeric = 1'b1; seg_last_pos = LAST_POS;
      end
   end

   assign seg_last   = (pos_ff == seg_last_pos);
   assign is_digit   = req_tdata inside {[ASCII_ZERO:ASCII_NINE]};
   assign digit_diff = req_tdata - ASCII_ZERO;
   assign acc_x10    = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0};
   assign acc_step   = acc_x10 + (is_digit ? {{(ACC_W-4){1'b0}}, digit_diff[3:0]}
                                           : {ACC_W{1'b0}});

   always_comb begin
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.field_id     = seg_id;
         rsp_in.text_byte    = 8'd0;
         rsp_in.text_valid   = 1'b0;
         rsp_in.number       = {ACC_W{1'b0}};
         rsp_in.number_valid = 1'b0;
         rsp_in.bad_digit    = 1'b0;
         rsp_in.record_last  = (pos_ff == LAST_POS);
         pos_in = (pos_ff == LAST_POS) ? {POS_W{1'b0}} : pos_ff + POS_W'(1);
         if (!seg_numeric) begin
            rsp_in.text_byte  = req_tdata;
            rsp_in.text_valid = 1'b1;
         end else begin
            if (req_tdata == ASCII_NUL) begin
               stop_in = 1'b1;
            end else begin
               rsp_in.bad_digit = !is_digit;
               if (!stop_ff) begin
                  acc_in = acc_step;
               end
            end
            if (seg_last) begin
               rsp_in.number       = acc_in;
               rsp_in.number_valid = 1'b1;
               acc_in              = {ACC_W{1'b0}};
               stop_in             = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= {POS_W{1'b0}};
         acc_ff       <= {ACC_W{1'b0}};
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - ACC_W - 8){1'b0}}, rsp_ff.number, rsp_ff.text_byte};
   assign rsp_tuser  = {1'b0, rsp_ff.bad_digit, rsp_ff.number_valid, rsp_ff.text_valid,
                        rsp_ff.field_id};
   assign rsp_tlast  = rsp_ff.record_last;

`ifndef SYNTHESIS
   a_pos_in_record: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position beyond record end");

   a_text_xor_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.text_valid && rsp_ff.number_valid))
      else $error("item tagged both text and number");

   a_bad_only_numeric: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bad_digit) |-> !rsp_ff.text_valid)
      else $error("bad digit flagged in text field");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff == LAST_POS) |=> (pos_ff == {POS_W{1'b0}} && acc_ff == {ACC_W{1'b0}}))
      else $error("record end did not restart position and accumulator");

   a_field_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && seg_numeric && seg_last) |=> (!stop_ff && acc_ff == {ACC_W{1'b0}}))
      else $error("numeric field end left state behind");
`endif

endmodule
`default_nettype wire
